### rtl/aalr_pkg.sv
// Shared types and codes for the accumulator ALU with link roll.
package aalr_pkg;

   localparam int unsigned DataWidth = 16;
   localparam int unsigned IrWidth   = 5;
   localparam int unsigned CmdWidth  = 3;

   // Operation codes; code 7 is a no-op handled by default arms
   typedef enum logic [CmdWidth-1:0] {
      CMD_ADD    = 3'd0,
      CMD_AND    = 3'd1,
      CMD_OR     = 3'd2,
      CMD_XOR    = 3'd3,
      CMD_NOT    = 3'd4,
      CMD_ROLL   = 3'd5,
      CMD_BRANCH = 3'd6
   } cmd_type;

   // Roll modes in the low three instruction bits; others pass L:A through
   localparam logic [2:0] ROLL_RIGHT_BIT    = 3'd1;
   localparam logic [2:0] ROLL_LEFT_BIT     = 3'd2;
   localparam logic [2:0] ROLL_RIGHT_NIBBLE = 3'd5;
   localparam logic [2:0] ROLL_LEFT_NIBBLE  = 3'd6;

   typedef struct packed {
      logic [CmdWidth-1:0]  cmd;
      logic [DataWidth-1:0] operand_a;
      logic [DataWidth-1:0] operand_b;
      logic                 link_in;
      logic                 overflow_in;
      logic [IrWidth-1:0]   ir_bits;
   } req_type;

   typedef struct packed {
      logic [DataWidth-1:0] result;
      logic                 link_out;
      logic                 overflow_out;
      logic                 negative;
      logic                 zero;
      logic                 cond_true;
   } rsp_type;

endpackage

### rtl/aalr_if.sv
// Valid/ready channel interfaces for the request and response items.
interface aalr_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [aalr_pkg::CmdWidth-1:0]         cmd;
   logic [aalr_pkg::DataWidth-1:0]        operand_a;
   logic [aalr_pkg::DataWidth-1:0]        operand_b;
   logic                                  link_in;
   logic                                  overflow_in;
   logic [aalr_pkg::IrWidth-1:0]          ir_bits;

   modport source (output valid, cmd, operand_a, operand_b, link_in, overflow_in, ir_bits,
                   input ready);
   modport sink   (input valid, cmd, operand_a, operand_b, link_in, overflow_in, ir_bits,
                   output ready);
endinterface

interface aalr_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [aalr_pkg::DataWidth-1:0]        result;
   logic                                  link_out;
   logic                                  overflow_out;
   logic                                  negative;
   logic                                  zero;
   logic                                  cond_true;

   modport source (output valid, result, link_out, overflow_out, negative, zero, cond_true,
                   input ready);
   modport sink   (input valid, result, link_out, overflow_out, negative, zero, cond_true,
                   output ready);
endinterface

### rtl/accumulator_alu_with_link_roll.sv
// Top level: registered single-pass accumulator ALU with link roll.
//
// Usage:
//   req_chan carries one operation item per handshake: cmd, operand_a,
//   operand_b, link_in, overflow_in and ir_bits. rsp_chan returns one item
//   per request: result, link_out, overflow_out, negative, zero, cond_true.
//   Both channels move an item on a clock edge with valid and ready high.
//   An item is captured in the input register, passes the combinational ALU
//   logic and lands in the output register, from which the response is
//   offered on rsp_chan until it is taken.
//   Throughput is one item per cycle while the receiver keeps ready high,
//   set by the single ALU pass between the two registers.
//   When the receiver stalls, the output register holds its item and the
//   input register fills; req_chan.ready drops only when both are full.
//   Synchronous reset empties both registers; no item is in flight after.
module accumulator_alu_with_link_roll (
   input  logic               clock,
   input  logic               reset,
   aalr_req_if.sink           req_chan,
   aalr_rsp_if.source         rsp_chan
);

   logic              in_valid_ff;
   logic              in_valid_in;
   aalr_pkg::req_type in_data_ff;
   aalr_pkg::req_type in_data_in;
   logic              out_valid_ff;
   logic              out_valid_in;
   aalr_pkg::rsp_type out_data_ff;
   aalr_pkg::rsp_type out_data_in;
   aalr_pkg::rsp_type alu_rsp;
   logic              out_free;
   logic              in_free;

   // Advance when the next stage is empty or draining
   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign in_free        = !in_valid_ff || out_free;
   assign req_chan.ready = in_free;

   // Capture the request item
   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (in_free) begin
         in_valid_in           = req_chan.valid;
         in_data_in.cmd        = req_chan.cmd;
         in_data_in.operand_a  = req_chan.operand_a;
         in_data_in.operand_b  = req_chan.operand_b;
         in_data_in.link_in    = req_chan.link_in;
         in_data_in.overflow_in = req_chan.overflow_in;
         in_data_in.ir_bits    = req_chan.ir_bits;
      end
   end

   aalr_alu u_alu (
      .req (in_data_ff),
      .rsp (alu_rsp)
   );

   // Load the result register, hold it while stalled
   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (out_free) begin
         out_valid_in = in_valid_ff;
         out_data_in  = alu_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   // Drive the response channel
   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.result       = out_data_ff.result;
   assign rsp_chan.link_out     = out_data_ff.link_out;
   assign rsp_chan.overflow_out = out_data_ff.overflow_out;
   assign rsp_chan.negative     = out_data_ff.negative;
   assign rsp_chan.zero         = out_data_ff.zero;
   assign rsp_chan.cond_true    = out_data_ff.cond_true;

endmodule

### rtl/aalr_alu.sv
// Combinational ALU: add, logic ops, 17-bit link roll and branch test.
module aalr_alu (
   input  aalr_pkg::req_type req,
   output aalr_pkg::rsp_type rsp
);

   logic [aalr_pkg::DataWidth:0]   sum;
   logic [aalr_pkg::DataWidth:0]   pair;
   logic [aalr_pkg::DataWidth:0]   rolled;
   logic [aalr_pkg::DataWidth-1:0] res;
   logic                           link_next;
   logic                           ovf_next;
   logic                           cond;
   logic                           a_neg;
   logic                           a_zero;

   assign sum    = {1'b0, req.operand_a} + {1'b0, req.operand_b};
   assign pair   = {req.link_in, req.operand_a};
   assign a_neg  = req.operand_a[aalr_pkg::DataWidth-1];
   assign a_zero = (req.operand_a == '0);

   // Rotate the L:A pair
   always_comb begin
      unique case (req.ir_bits[2:0])
         aalr_pkg::ROLL_LEFT_NIBBLE:  rolled = {pair[12:0], pair[16:13]};
         aalr_pkg::ROLL_RIGHT_NIBBLE: rolled = {pair[3:0], pair[16:4]};
         aalr_pkg::ROLL_LEFT_BIT:     rolled = {pair[15:0], pair[16]};
         aalr_pkg::ROLL_RIGHT_BIT:    rolled = {pair[0], pair[16:1]};
         default:                     rolled = pair;
      endcase
   end

   // Select the operation
   always_comb begin
      res       = '0;
      link_next = req.link_in;
      ovf_next  = req.overflow_in;
      cond      = 1'b0;
      unique case (aalr_pkg::cmd_type'(req.cmd))
         aalr_pkg::CMD_ADD: begin
            res       = sum[aalr_pkg::DataWidth-1:0];
            link_next = req.link_in ^ sum[aalr_pkg::DataWidth];
            ovf_next  = (req.operand_a[15] == req.operand_b[15]) &&
                        (req.operand_a[15] != sum[15]);
         end
         aalr_pkg::CMD_AND: res = req.operand_a & req.operand_b;
         aalr_pkg::CMD_OR:  res = req.operand_a | req.operand_b;
         aalr_pkg::CMD_XOR: res = req.operand_a ^ req.operand_b;
         aalr_pkg::CMD_NOT: res = ~req.operand_a;
         aalr_pkg::CMD_ROLL: begin
            res       = rolled[aalr_pkg::DataWidth-1:0];
            link_next = rolled[aalr_pkg::DataWidth];
         end
         aalr_pkg::CMD_BRANCH: begin
            cond = ((a_neg & req.ir_bits[3]) | (a_zero & req.ir_bits[2]) |
                    (req.link_in & req.ir_bits[1]) | (req.overflow_in & req.ir_bits[0]))
                   ^ req.ir_bits[4];
         end
         default: res = '0;
      endcase
   end

   assign rsp.result       = res;
   assign rsp.link_out     = link_next;
   assign rsp.overflow_out = ovf_next;
   assign rsp.negative     = res[aalr_pkg::DataWidth-1];
   assign rsp.zero         = (res == '0);
   assign rsp.cond_true    = cond;

endmodule

### rtl/aalr_checker.sv
// Port-level checker for the accumulator ALU, bound to the top level.
module aalr_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [aalr_pkg::DataWidth-1:0] rsp_result,
   input logic                           rsp_negative,
   input logic                           rsp_zero,
   input logic                           rsp_cond_true
);

   // Hold a stalled response item
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result))
      else $error("stalled response item changed");

   // Zero flag tracks the result value
   a_zero_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_zero == (rsp_result == '0)))
      else $error("zero flag does not match result");

   // Negative flag is the sign bit of the result
   a_neg_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_negative == rsp_result[aalr_pkg::DataWidth-1]))
      else $error("negative flag does not match result");

   // A true branch test drives no value
   a_cond_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cond_true |-> rsp_zero && (rsp_result == '0))
      else $error("branch test item carries a nonzero result");

endmodule

bind accumulator_alu_with_link_roll aalr_checker u_aalr_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_result    (rsp_chan.result),
   .rsp_negative  (rsp_chan.negative),
   .rsp_zero      (rsp_chan.zero),
   .rsp_cond_true (rsp_chan.cond_true)
);
